// ===== rtl/sorted_range_search_unit_macros.svh =====
// Assertion macros used by the checker of the sorted range search unit.
`ifndef SORTED_RANGE_SEARCH_UNIT_MACROS_SVH
`define SORTED_RANGE_SEARCH_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SRS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/srs_pkg.sv =====
// Shared types and constants of the sorted range search unit.
package srs_pkg;

	localparam int DATA_W        = 32;
	localparam int IDX_W         = 10;
	localparam int CNT_W         = 11;
	localparam int DEPTH_DEFAULT = 1024;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic                     opcode;
		logic [IDX_W-1:0]         entry_index;
		logic signed [DATA_W-1:0] value;
	} srs_in_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] last_index;
	} srs_out_t;

endpackage

// ===== rtl/srs_store.sv =====
// Synchronous single-port-write, single-port-read memory holding the sorted entries.
module srs_store #(
	parameter int DEPTH = srs_pkg::DEPTH_DEFAULT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [AW-1:0]                    wr_addr,
	input  logic signed [srs_pkg::DATA_W-1:0] wr_data,
	input  logic                             rd_en,
	input  logic [AW-1:0]                    rd_addr,
	output logic signed [srs_pkg::DATA_W-1:0] rd_data
);

	logic signed [srs_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/srs_ctrl.sv =====
// Search sequencer that runs the lower-bound and upper-bound probes against the store.
module srs_ctrl #(
	parameter int DEPTH = srs_pkg::DEPTH_DEFAULT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [srs_pkg::DATA_W-1:0] key,
	input  logic [AW-1:0]                     last_pos,
	output logic                              rd_en,
	output logic [AW-1:0]                     rd_addr,
	input  logic signed [srs_pkg::DATA_W-1:0] rd_data,
	output logic                              busy,
	output logic                              res_valid,
	input  logic                              res_take,
	output srs_pkg::srs_out_t                 res
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_LB_ISSUE = 3'd1;
	localparam logic [2:0] ST_LB_EVAL  = 3'd2;
	localparam logic [2:0] ST_CHK_EVAL = 3'd3;
	localparam logic [2:0] ST_UB_ISSUE = 3'd4;
	localparam logic [2:0] ST_UB_EVAL  = 3'd5;
	localparam logic [2:0] ST_DONE     = 3'd6;

	logic [2:0]                        state_q;
	logic [AW-1:0]                     lo_q;
	logic [AW-1:0]                     hi_q;
	logic [AW-1:0]                     mid_q;
	logic [AW-1:0]                     first_q;
	logic [AW-1:0]                     last_pos_q;
	logic signed [srs_pkg::DATA_W-1:0] key_q;
	logic                              found_q;
	logic [AW:0]                       sum_lb;
	logic [AW:0]                       sum_ub;
	logic [AW-1:0]                     mid_lb;
	logic [AW-1:0]                     mid_ub;

	assign sum_lb = {1'b0, lo_q} + {1'b0, hi_q};
	assign sum_ub = sum_lb + {{AW{1'b0}}, 1'b1};
	assign mid_lb = sum_lb[AW:1];
	assign mid_ub = sum_ub[AW:1];

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = lo_q;
		unique case (state_q)
			ST_LB_ISSUE: begin
				rd_en   = 1'b1;
				rd_addr = (lo_q < hi_q) ? mid_lb : lo_q;
			end
			ST_UB_ISSUE: begin
				rd_en   = lo_q < hi_q;
				rd_addr = mid_ub;
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = lo_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						lo_q       <= '0;
						hi_q       <= last_pos;
						last_pos_q <= last_pos;
						key_q      <= key;
						state_q    <= ST_LB_ISSUE;
					end
				end
				ST_LB_ISSUE: begin
					mid_q   <= mid_lb;
					state_q <= (lo_q < hi_q) ? ST_LB_EVAL : ST_CHK_EVAL;
				end
				ST_LB_EVAL: begin
					if (!(rd_data < key_q)) begin
						hi_q <= mid_q;
					end else begin
						lo_q <= mid_q + AW'(1);
					end
					state_q <= ST_LB_ISSUE;
				end
				ST_CHK_EVAL: begin
					if (rd_data != key_q) begin
						found_q <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						first_q <= lo_q;
						lo_q    <= '0;
						hi_q    <= last_pos_q;
						state_q <= ST_UB_ISSUE;
					end
				end
				ST_UB_ISSUE: begin
					mid_q <= mid_ub;
					if (lo_q < hi_q) begin
						state_q <= ST_UB_EVAL;
					end else begin
						found_q <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_UB_EVAL: begin
					if (!(key_q < rd_data)) begin
						lo_q <= mid_q;
					end else begin
						hi_q <= mid_q - AW'(1);
					end
					state_q <= ST_UB_ISSUE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = state_q != ST_IDLE;
	assign res_valid = state_q == ST_DONE;

	always_comb begin
		res.found       = found_q;
		res.first_index = found_q ? srs_pkg::IDX_W'(first_q) : '0;
		res.last_index  = found_q ? srs_pkg::IDX_W'(lo_q) : '0;
	end

endmodule

// ===== rtl/sorted_range_search_unit.sv =====
// Top level of the sorted range search unit: store, search sequencer and result register.
//
//   Channel  Signals                       Direction  Moves
//   req      req_valid, req_stall, req     in         load of one entry or query of one key
//   rsp      rsp_valid, rsp_stall, rsp     out        found flag, first and last position
//   cfg      cfg_we, cfg_wdata             in         element count, written without wait
//
// A load produces no result.
// In a query, each probe of the two binary searches reads the store in an issue state
// and evaluates the read word in an evaluate state.
// The request side is stalled while a query runs; the result register holds one
// result, so a new request is taken while a result still waits on the response side.
// Reset clears the control state and sets the element count to one; the store is not cleared.
module sorted_range_search_unit #(
	parameter int DEPTH = srs_pkg::DEPTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  srs_pkg::srs_in_t           req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output srs_pkg::srs_out_t          rsp,
	input  logic                       cfg_we,
	input  logic [srs_pkg::CNT_W-1:0]  cfg_wdata
);

	localparam int AW = $clog2(DEPTH);

	logic [srs_pkg::CNT_W-1:0]         count_q;
	logic [AW-1:0]                     last_pos;
	logic                              req_xfer;
	logic                              store_we;
	logic                              rd_en;
	logic [AW-1:0]                     rd_addr;
	logic signed [srs_pkg::DATA_W-1:0] rd_data;
	logic                              busy;
	logic                              res_valid;
	logic                              res_take;
	srs_pkg::srs_out_t                 res;
	logic                              rsp_valid_q;
	srs_pkg::srs_out_t                 rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= srs_pkg::CNT_W'(1);
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (count_q == '0) begin
			last_pos = '0;
		end else if (32'(count_q) > 32'(DEPTH)) begin
			last_pos = AW'(DEPTH - 1);
		end else begin
			last_pos = AW'(count_q - srs_pkg::CNT_W'(1));
		end
	end

	assign req_stall = busy;
	assign req_xfer  = req_valid && !req_stall;
	assign store_we  = req_xfer && (req.opcode == srs_pkg::OP_LOAD) &&
		(32'(req.entry_index) < 32'(DEPTH));

	srs_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (store_we),
		.wr_addr (AW'(req.entry_index)),
		.wr_data (req.value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	srs_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req_xfer && (req.opcode == srs_pkg::OP_QUERY)),
		.key       (req.value),
		.last_pos  (last_pos),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.busy      (busy),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/srs_checker.sv =====
// Port-level checker of the sorted range search unit and its bind statement.
`include "sorted_range_search_unit_macros.svh"

module srs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_stall,
	input srs_pkg::srs_in_t          req,
	input logic                      rsp_valid,
	input logic                      rsp_stall,
	input srs_pkg::srs_out_t         rsp
);

	logic take_query;
	logic take_load;
	logic rsp_wait;
	logic rsp_miss;
	logic pos_zero;

	assign take_query = req_valid && !req_stall && (req.opcode == srs_pkg::OP_QUERY);
	assign take_load  = req_valid && !req_stall && (req.opcode == srs_pkg::OP_LOAD);
	assign rsp_wait   = rsp_valid && rsp_stall;
	assign rsp_miss   = rsp_valid && !rsp.found;
	assign pos_zero   = (rsp.first_index == '0) && (rsp.last_index == '0);

	`SRS_ASSERT_NEXT(a_rsp_held, clk, arst_n, rsp_wait, rsp_valid && $stable(rsp), "Held response changed.")
	`SRS_ASSERT_NEXT(a_query_busy, clk, arst_n, take_query, req_stall, "Query did not stall requests.")
	`SRS_ASSERT_NEXT(a_load_free, clk, arst_n, take_load, !req_stall, "Load stalled requests.")
	`SRS_ASSERT_SAME(a_miss_zero, clk, arst_n, rsp_miss, pos_zero, "Miss reported nonzero positions.")
	`SRS_ASSERT_SAME(a_rsp_src, clk, arst_n, $rose(rsp_valid), $past(req_stall), "Unprompted response.")

endmodule

bind sorted_range_search_unit srs_checker u_srs_checker (.*);
